// File: sv/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

    // sizing
    localparam int CORDIC_STEPS = 16;
    localparam int POS_WIDTH    = 32;
    localparam int ITER_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int ATAN_IDX_W   = 5;

    // field and datapath widths
    localparam int DELTA_W = 16;
    localparam int GAIN_W  = 16;
    localparam int COORD_W = 32;
    localparam int HEAD_W  = 20;
    localparam int DPROD_W = 34;
    localparam int DIST_W  = 20;
    localparam int TURN_W  = 21;
    localparam int MID_W   = 22;
    localparam int CORD_W  = 34;
    localparam int MULB_W  = 33;
    localparam int PROD_W  = DIST_W + MULB_W;
    localparam int STEP_W  = PROD_W - 30;
    localparam int SUM_W   = (POS_WIDTH > COORD_W) ? POS_WIDTH : COORD_W;

    // angle and rounding constants
    localparam int TWO_PI_Q16  = 411775;
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    localparam int GAIN_Q30    = 652032874;
    localparam int HEAD_MAX    = 524287;
    localparam int HEAD_MIN    = -524288;
    localparam int ROUND30     = 2 ** 29;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam logic [2:0] REG_WHEEL_RADIUS  = 3'd0;
    localparam logic [2:0] REG_TURN_GAIN     = 3'd1;
    localparam logic [2:0] REG_START_X       = 3'd2;
    localparam logic [2:0] REG_START_Y       = 3'd3;
    localparam logic [2:0] REG_START_HEADING = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_RED,
        ST_ITER,
        ST_PX,
        ST_PY,
        ST_WB
    } state_t;

    typedef struct packed {
        logic              load_in;
        logic              mul;
        logic              rnd;
        logic              red;
        logic              iter;
        logic              px;
        logic              py;
        logic              wb;
        logic [ITER_W-1:0] iter_idx;
    } cmd_t;

    typedef struct packed {
        logic        [GAIN_W-1:0]  wheel_radius;
        logic        [GAIN_W-1:0]  turn_gain;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [HEAD_W-1:0]  start_heading;
    } cfg_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic signed [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:    v = 32'sd843314856;
            5'd1:    v = 32'sd497837829;
            5'd2:    v = 32'sd263043836;
            5'd3:    v = 32'sd133525158;
            5'd4:    v = 32'sd67021686;
            5'd5:    v = 32'sd33543515;
            5'd6:    v = 32'sd16775850;
            5'd7:    v = 32'sd8388437;
            5'd8:    v = 32'sd4194282;
            5'd9:    v = 32'sd2097149;
            5'd10:   v = 32'sd1048575;
            5'd11:   v = 32'sd524287;
            5'd12:   v = 32'sd262143;
            5'd13:   v = 32'sd131071;
            5'd14:   v = 32'sd65535;
            5'd15:   v = 32'sd32767;
            5'd16:   v = 32'sd16383;
            5'd17:   v = 32'sd8191;
            5'd18:   v = 32'sd4095;
            5'd19:   v = 32'sd2047;
            5'd20:   v = 32'sd1023;
            5'd21:   v = 32'sd511;
            5'd22:   v = 32'sd255;
            5'd23:   v = 32'sd127;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/differential_drive_odometry_core.sv
// An accepted item runs the multiply, rounding and range-reduction states, then 16 CORDIC steps,
// then the x and y steps on the shared multiplier and write-back, before m_tvalid is raised.
// A new item is taken only in idle, after the last one is written back; one CORDIC step per cycle.
// A finished result waits in the output register while the next item is worked on.
// Reset (aresetn, synchronous, active low) clears position and heading and loads
// the configuration defaults.
`timescale 1ns / 1ps

module differential_drive_odometry_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ddo_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // left_delta[15:0], right_delta[31:16]
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [87:0]                     m_tdata   // pos_x[31:0], pos_y[63:32],
                                                      // heading_out[83:64], zero[87:84]
);

    logic [ddo_pkg::GAIN_W-1:0]         wheel_radius_reg;
    logic [ddo_pkg::GAIN_W-1:0]         turn_gain_reg;
    logic signed [ddo_pkg::COORD_W-1:0] start_x_reg;
    logic signed [ddo_pkg::COORD_W-1:0] start_y_reg;
    logic signed [ddo_pkg::HEAD_W-1:0]  start_heading_reg;

    logic [2:0]                         reg_idx;
    logic                               wr_en;
    logic                               hd_load;
    ddo_pkg::cfg_t                      cfg;
    ddo_pkg::cmd_t                      cmd;
    logic signed [ddo_pkg::COORD_W-1:0] pos_x, pos_y;
    logic signed [ddo_pkg::HEAD_W-1:0]  heading_out;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign hd_load = wr_en && (reg_idx == ddo_pkg::REG_START_HEADING);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_radius_reg  <= ddo_pkg::GAIN_W'(6390);
            turn_gain_reg     <= ddo_pkg::GAIN_W'(8824);
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_heading_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                ddo_pkg::REG_WHEEL_RADIUS:  wheel_radius_reg  <= pwdata[15:0];
                ddo_pkg::REG_TURN_GAIN:     turn_gain_reg     <= pwdata[15:0];
                ddo_pkg::REG_START_X:       start_x_reg       <= pwdata;
                ddo_pkg::REG_START_Y:       start_y_reg       <= pwdata;
                ddo_pkg::REG_START_HEADING: start_heading_reg <= pwdata[19:0];
                default: begin
                end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            ddo_pkg::REG_WHEEL_RADIUS:  prdata = {16'd0, wheel_radius_reg};
            ddo_pkg::REG_TURN_GAIN:     prdata = {16'd0, turn_gain_reg};
            ddo_pkg::REG_START_X:       prdata = start_x_reg;
            ddo_pkg::REG_START_Y:       prdata = start_y_reg;
            ddo_pkg::REG_START_HEADING: prdata = 32'(start_heading_reg);
            default:                    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.wheel_radius  = wheel_radius_reg;
        cfg.turn_gain     = turn_gain_reg;
        cfg.start_x       = start_x_reg;
        cfg.start_y       = start_y_reg;
        cfg.start_heading = start_heading_reg;
    end

    ddo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ddo_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg         (cfg),
        .hd_load     (hd_load),
        .hd_value    (pwdata[ddo_pkg::HEAD_W-1:0]),
        .left_delta  (s_tdata[15:0]),
        .right_delta (s_tdata[31:16]),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading_out (heading_out)
    );

    assign m_tdata = {4'd0, heading_out, pos_y, pos_x};

endmodule

// File: sv/ddo_ctrl.sv
`timescale 1ns / 1ps

module ddo_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output ddo_pkg::cmd_t  cmd
);

    ddo_pkg::state_t                state_reg, state_next;
    logic [ddo_pkg::ITER_W-1:0]     iter_cnt_reg, iter_cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic                           iter_last;
    logic                           wb_ok;

    assign iter_last = (iter_cnt_reg == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_STEPS - 1));
    assign wb_ok     = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ddo_pkg::ST_IDLE: if (s_tvalid) state_next = ddo_pkg::ST_MUL;
            ddo_pkg::ST_MUL:  state_next = ddo_pkg::ST_RND;
            ddo_pkg::ST_RND:  state_next = ddo_pkg::ST_RED;
            ddo_pkg::ST_RED:  state_next = ddo_pkg::ST_ITER;
            ddo_pkg::ST_ITER: if (iter_last) state_next = ddo_pkg::ST_PX;
            ddo_pkg::ST_PX:   state_next = ddo_pkg::ST_PY;
            ddo_pkg::ST_PY:   state_next = ddo_pkg::ST_WB;
            ddo_pkg::ST_WB:   if (wb_ok) state_next = ddo_pkg::ST_IDLE;
            default:          state_next = ddo_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd          = '0;
        cmd.iter_idx = iter_cnt_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            ddo_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ddo_pkg::ST_MUL:  cmd.mul  = 1'b1;
            ddo_pkg::ST_RND:  cmd.rnd  = 1'b1;
            ddo_pkg::ST_RED:  cmd.red  = 1'b1;
            ddo_pkg::ST_ITER: cmd.iter = 1'b1;
            ddo_pkg::ST_PX:   cmd.px   = 1'b1;
            ddo_pkg::ST_PY:   cmd.py   = 1'b1;
            ddo_pkg::ST_WB:   cmd.wb   = wb_ok;
            default: begin
                cmd = '0;
            end
        endcase
    end

    // iteration counter and result valid
    always_comb begin
        iter_cnt_next = iter_cnt_reg;
        if (state_reg == ddo_pkg::ST_ITER) begin
            iter_cnt_next = iter_last ? '0 : iter_cnt_reg + 1'b1;
        end
        if (cmd.wb) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ddo_pkg::ST_IDLE;
            iter_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            iter_cnt_reg <= iter_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // counter only runs during the rotation steps
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ddo_pkg::ST_ITER) |-> (iter_cnt_reg == '0))
        else $error("iteration counter nonzero outside rotation");

    // an accepted item starts the multiply step
    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ddo_pkg::ST_MUL))
        else $error("accepted item did not start");

    // at most one datapath step per cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_in, cmd.mul, cmd.rnd, cmd.red, cmd.iter, cmd.px, cmd.py, cmd.wb}))
        else $error("more than one datapath command");

    // write-back always presents a result
    a_wb_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |=> m_tvalid_reg)
        else $error("write-back without result valid");

endmodule

// File: sv/ddo_dp.sv
`timescale 1ns / 1ps

module ddo_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ddo_pkg::cmd_t                        cmd,
    input  ddo_pkg::cfg_t                        cfg,
    input  logic                                 hd_load,
    input  logic signed [ddo_pkg::HEAD_W-1:0]    hd_value,
    input  logic signed [ddo_pkg::DELTA_W-1:0]   left_delta,
    input  logic signed [ddo_pkg::DELTA_W-1:0]   right_delta,
    output logic signed [ddo_pkg::COORD_W-1:0]   pos_x,
    output logic signed [ddo_pkg::COORD_W-1:0]   pos_y,
    output logic signed [ddo_pkg::HEAD_W-1:0]    heading_out
);

    logic signed [ddo_pkg::DELTA_W-1:0]   left_reg, right_reg;
    logic signed [ddo_pkg::DPROD_W-1:0]   dprod_reg, tprod_reg;
    logic signed [ddo_pkg::DIST_W-1:0]    dist_reg;
    logic signed [ddo_pkg::TURN_W-1:0]    turn_reg;
    logic signed [ddo_pkg::MID_W-1:0]     mid_reg;
    logic                                 flip_reg;
    logic signed [ddo_pkg::CORD_W-1:0]    cx_reg, cy_reg, cz_reg;
    logic signed [ddo_pkg::PROD_W-1:0]    prod_x_reg, prod_y_reg;
    logic signed [ddo_pkg::POS_WIDTH-1:0] acc_x_reg, acc_x_next;
    logic signed [ddo_pkg::POS_WIDTH-1:0] acc_y_reg, acc_y_next;
    logic signed [ddo_pkg::HEAD_W-1:0]    heading_reg, heading_next;

    logic signed [ddo_pkg::DELTA_W:0]     wsum, wdiff;
    logic signed [ddo_pkg::DPROD_W-1:0]   dprod, tprod;
    logic signed [ddo_pkg::DPROD_W-1:0]   dist_full, turn_full;
    logic signed [ddo_pkg::DIST_W-1:0]    dist_rnd;
    logic signed [ddo_pkg::TURN_W-1:0]    turn_rnd;
    logic signed [ddo_pkg::MID_W-1:0]     half_turn, mid_val;
    logic signed [ddo_pkg::MID_W-1:0]     ang;
    logic                                 flip;
    logic signed [ddo_pkg::CORD_W-1:0]    z_init;
    logic signed [ddo_pkg::CORD_W-1:0]    dx, dy, atan_v;
    logic signed [ddo_pkg::MULB_W-1:0]    mul_b;
    logic signed [ddo_pkg::PROD_W-1:0]    prod;
    logic signed [ddo_pkg::PROD_W-1:0]    sum_x, sum_y;
    logic signed [ddo_pkg::STEP_W-1:0]    step_x, step_y;
    logic signed [ddo_pkg::MID_W-1:0]     h_raw, h_wrap;
    logic signed [ddo_pkg::SUM_W-1:0]     acc_x_ext, acc_y_ext;

    // wheel products
    always_comb begin
        wsum  = (ddo_pkg::DELTA_W+1)'(left_reg) + (ddo_pkg::DELTA_W+1)'(right_reg);
        wdiff = (ddo_pkg::DELTA_W+1)'(right_reg) - (ddo_pkg::DELTA_W+1)'(left_reg);
        dprod = ddo_pkg::DPROD_W'(wsum)
              * ddo_pkg::DPROD_W'(signed'({1'b0, cfg.wheel_radius}));
        tprod = ddo_pkg::DPROD_W'(wdiff)
              * ddo_pkg::DPROD_W'(signed'({1'b0, cfg.turn_gain}));
    end

    // distance, heading change and mid-step heading
    always_comb begin
        dist_full = (dprod_reg + ddo_pkg::DPROD_W'(8192)) >>> 14;
        turn_full = (tprod_reg + ddo_pkg::DPROD_W'(4096)) >>> 13;
        dist_rnd  = ddo_pkg::DIST_W'(dist_full);
        turn_rnd  = ddo_pkg::TURN_W'(turn_full);
        half_turn = (ddo_pkg::MID_W'(turn_rnd) + ddo_pkg::MID_W'(1)) >>> 1;
        mid_val   = ddo_pkg::MID_W'(heading_reg) + half_turn;
    end

    // angle range reduction into the right half plane
    always_comb begin
        ang  = mid_reg;
        flip = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (ang > ddo_pkg::PI_Q16) ang = ang - ddo_pkg::MID_W'(ddo_pkg::TWO_PI_Q16);
            if (ang < -ddo_pkg::PI_Q16) ang = ang + ddo_pkg::MID_W'(ddo_pkg::TWO_PI_Q16);
        end
        if (ang > ddo_pkg::HALF_PI_Q16) begin
            ang  = ang - ddo_pkg::MID_W'(ddo_pkg::PI_Q16);
            flip = 1'b1;
        end else if (ang < -ddo_pkg::HALF_PI_Q16) begin
            ang  = ang + ddo_pkg::MID_W'(ddo_pkg::PI_Q16);
            flip = 1'b1;
        end
        z_init = ddo_pkg::CORD_W'(ang) <<< 14;
    end

    // one rotation step
    always_comb begin
        dx     = cy_reg >>> cmd.iter_idx;
        dy     = cx_reg >>> cmd.iter_idx;
        atan_v = ddo_pkg::CORD_W'(ddo_pkg::atan_q30(ddo_pkg::ATAN_IDX_W'(cmd.iter_idx)));
    end

    // shared multiplier for the x and y steps
    always_comb begin
        if (cmd.px) begin
            mul_b = ddo_pkg::MULB_W'(flip_reg ? -cx_reg : cx_reg);
        end else begin
            mul_b = ddo_pkg::MULB_W'(flip_reg ? -cy_reg : cy_reg);
        end
        prod = ddo_pkg::PROD_W'(dist_reg) * ddo_pkg::PROD_W'(mul_b);
    end

    // position and heading update
    always_comb begin
        sum_x      = prod_x_reg + ddo_pkg::PROD_W'(ddo_pkg::ROUND30);
        sum_y      = prod_y_reg + ddo_pkg::PROD_W'(ddo_pkg::ROUND30);
        step_x     = ddo_pkg::STEP_W'(sum_x >>> 30);
        step_y     = ddo_pkg::STEP_W'(sum_y >>> 30);
        acc_x_next = acc_x_reg + ddo_pkg::POS_WIDTH'(step_x);
        acc_y_next = acc_y_reg + ddo_pkg::POS_WIDTH'(step_y);

        h_raw  = ddo_pkg::MID_W'(heading_reg) + ddo_pkg::MID_W'(turn_reg);
        h_wrap = h_raw;
        if (h_raw < -ddo_pkg::TWO_PI_Q16) begin
            h_wrap = h_raw + ddo_pkg::MID_W'(ddo_pkg::TWO_PI_Q16);
        end else if (h_raw > ddo_pkg::TWO_PI_Q16) begin
            h_wrap = h_raw - ddo_pkg::MID_W'(ddo_pkg::TWO_PI_Q16);
        end
        if (h_wrap > ddo_pkg::HEAD_MAX) begin
            heading_next = ddo_pkg::HEAD_W'(ddo_pkg::HEAD_MAX);
        end else if (h_wrap < ddo_pkg::HEAD_MIN) begin
            heading_next = ddo_pkg::HEAD_W'(ddo_pkg::HEAD_MIN);
        end else begin
            heading_next = ddo_pkg::HEAD_W'(h_wrap);
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            left_reg  <= left_delta;
            right_reg <= right_delta;
        end
        if (cmd.mul) begin
            dprod_reg <= dprod;
            tprod_reg <= tprod;
        end
        if (cmd.rnd) begin
            dist_reg <= dist_rnd;
            turn_reg <= turn_rnd;
            mid_reg  <= mid_val;
        end
        if (cmd.red) begin
            flip_reg <= flip;
            cx_reg   <= ddo_pkg::CORD_W'(ddo_pkg::GAIN_Q30);
            cy_reg   <= '0;
            cz_reg   <= z_init;
        end else if (cmd.iter) begin
            if (cz_reg >= 0) begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + atan_v;
            end
        end
        if (cmd.px) prod_x_reg <= prod;
        if (cmd.py) prod_y_reg <= prod;
    end

    // accumulated state, heading takes the written start value directly
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            heading_reg <= '0;
        end else begin
            if (cmd.wb) begin
                acc_x_reg   <= acc_x_next;
                acc_y_reg   <= acc_y_next;
                heading_reg <= heading_next;
            end else if (hd_load) begin
                heading_reg <= hd_value;
            end
        end
    end

    // result fields, stable while the result waits unless a start value is written
    assign acc_x_ext   = ddo_pkg::SUM_W'(acc_x_reg);
    assign acc_y_ext   = ddo_pkg::SUM_W'(acc_y_reg);
    assign pos_x       = acc_x_ext[ddo_pkg::COORD_W-1:0] + cfg.start_x;
    assign pos_y       = acc_y_ext[ddo_pkg::COORD_W-1:0] + cfg.start_y;
    assign heading_out = heading_reg;

endmodule
